FILE: rtl/core/tbseq_pkg.sv
// Shared types and constants of the three band saturating EQ.
// Register indexes, sequencer states and the state RAM map.
// No dependencies.
`default_nettype none

package tbseq_pkg;

  localparam int unsigned GUARD_BITS = 8;
  localparam logic [16:0] COEF_ONE = 17'd65536;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // Taylor series divisors (2k)(2k+1)
  localparam int unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  // State RAM map
  localparam int unsigned ENT_AW      = 6;
  localparam int unsigned NUM_ENTRIES = 36;
  localparam logic [ENT_AW-1:0] EMPH_BASE = 6'd0;
  localparam logic [ENT_AW-1:0] TREB_BASE = 6'd3;
  localparam logic [ENT_AW-1:0] BASS_BASE = 6'd9;
  localparam logic [ENT_AW-1:0] HP_BASE   = 6'd15;
  localparam logic [ENT_AW-1:0] LP_BASE   = 6'd25;

  typedef enum logic [2:0] {
    REG_TREBLE_DRIVE = 3'd0,
    REG_MID_DRIVE    = 3'd1,
    REG_BASS_DRIVE   = 3'd2,
    REG_TREBLE_SPLIT = 3'd3,
    REG_BASS_SPLIT   = 3'd4,
    REG_LOWPASS      = 3'd5,
    REG_HIGHPASS     = 3'd6,
    REG_OUT_GAIN     = 3'd7
  } reg_idx_e;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_EMPH  = 10'b00_0000_0010,
    S_TF    = 10'b00_0000_0100,
    S_SPLIT = 10'b00_0000_1000,
    S_MIX   = 10'b00_0001_0000,
    S_DRIVE = 10'b00_0010_0000,
    S_SUM   = 10'b00_0100_0000,
    S_HPF   = 10'b00_1000_0000,
    S_LPF   = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/three_band_saturating_eq.sv
// Three band EQ with per-band drive shaping, fixed point, top level.
// Uses tbseq_pkg and tbseq_ram (filter and emphasis state).
// The next request is taken only after the result of the last one is loaded,
// so samples go through one at a time. Each filter pole and each band drive
// takes its turn on the one shared multiplier and the single state RAM.
// Reset sets the configuration and control registers and clears the RAM valid bits; no clearing pass.
`default_nettype none

module three_band_saturating_eq #(
  parameter int unsigned SAMPLE_BITS      = 24,
  parameter int unsigned STATE_BITS       = 40,
  parameter int unsigned SINE_TABLE_DEPTH = 256
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // sample_in
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata_i,
  input  wire logic                                s_axis_tlast_i,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // sample_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]         m_axis_tdata_o,
  // clipped
  output logic                                     m_axis_tuser_o,
  output logic                                     m_axis_tlast_o,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [2:0]                          cfg_addr_i,
  input  wire logic [19:0]                         cfg_data_i
);

  import tbseq_pkg::*;

  localparam int unsigned TDW    = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned XB     = SAMPLE_BITS + GUARD_BITS;
  localparam int unsigned FRAC   = XB - 1;
  localparam int unsigned MAXB   = (STATE_BITS > XB) ? STATE_BITS : XB;
  localparam int unsigned EW     = MAXB + 3;
  localparam int unsigned MW     = EW + 21;
  localparam int unsigned PW     = MW - 16;
  localparam int unsigned TAB_AW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned PB     = FRAC + 1 + TAB_AW;

  localparam logic signed [EW-1:0] ONE_FX = {{(EW-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
  localparam logic signed [PW-1:0] ST_HI  =
      {{(PW-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] ST_LO  = ~ST_HI;
  localparam logic signed [PW-1:0] OUT_HI =
      {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] OUT_LO = ~OUT_HI;

  function automatic logic signed [STATE_BITS-1:0] sat_st(input logic signed [PW-1:0] v);
    if (v > ST_HI) begin
      sat_st = ST_HI[STATE_BITS-1:0];
    end else if (v < ST_LO) begin
      sat_st = ST_LO[STATE_BITS-1:0];
    end else begin
      sat_st = v[STATE_BITS-1:0];
    end
  endfunction

  function automatic logic [30:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (HALF_PI_Q30 * 64'(i)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 0; k < 8; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k & 1) == 0) sum = sum - signed'(term);
      else sum = sum + signed'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    if (i == 0) sum = 0;
    if (i == SINE_TABLE_DEPTH) sum = 64'sd1073741824;
    sine_entry = sum[30:0];
  endfunction

  logic [30:0] sin_tab [SINE_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_sin
    assign sin_tab[gi] = sine_entry(gi);
  end

  // configuration
  logic signed [17:0] td_q, md_q, bd_q;
  logic [16:0]        tsc_q, bsc_q, lpc_q, hpc_q;
  logic [19:0]        gain_q;
  logic [16:0]        ca, cb, clp, chp;
  logic               lp_on, hp_on;

  assign ca    = (tsc_q > COEF_ONE) ? COEF_ONE : tsc_q;
  assign cb    = (bsc_q > COEF_ONE) ? COEF_ONE : bsc_q;
  assign clp   = (lpc_q > COEF_ONE) ? COEF_ONE : lpc_q;
  assign chp   = (hpc_q > COEF_ONE) ? COEF_ONE : hpc_q;
  assign lp_on = clp < COEF_ONE;
  assign hp_on = chp != 17'd0;

  // control
  state_e           state_q;
  logic [2:0]       sub_q, idx_q;
  logic             tog_q;
  logic [1:0]       cnt_q, cnt_nx, k, k1, k2;
  logic [SAMPLE_BITS-1:0] prev_q;
  logic [NUM_ENTRIES-1:0] valid_q;
  logic             m_valid_q;
  logic             in_acc, out_load, pole_st;

  // datapath
  logic signed [XB-1:0]         x_q;
  logic signed [STATE_BITS-1:0] f_q, ek_q, tf_q, high_q, bass_q, mid_q, y_q, g_q;
  logic signed [STATE_BITS-1:0] s_q, x1_q;
  logic signed [EW-1:0]         diff_q, shp_q;
  logic signed [MW-1:0]         prod_q, mul_p;
  logic signed [PW-1:0]         prod_sh, m1_q;
  logic [PB-1:0]                pos_q;
  logic [30:0]                  base_q, tdiff_q;
  logic [15:0]                  fr_q;
  logic                         clamp_q, last_q, rd_valid_q;
  logic [SAMPLE_BITS-1:0]       m_data_q;
  logic                         m_clip_q, m_last_q;

  logic signed [EW-1:0]         mul_a;
  logic signed [20:0]           mul_b;
  logic [ENT_AW-1:0]            p_addr, emph_addr, raddr;
  logic signed [EW-1:0]         p_in;
  logic [16:0]                  p_coef;
  logic                         ram_we, ram_re;
  logic [STATE_BITS-1:0]        ram_wdata, ram_rdata;
  logic signed [STATE_BITS-1:0] rdm, s_val, p_new, emph_val, dv;
  logic signed [17:0]           dd;
  logic signed [18:0]           absd;
  logic signed [XB-1:0]         xin, prev_x;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = (state_q == S_OUT) && (sub_q == 3'd2) && (!m_valid_q || m_axis_tready_i);
  assign pole_st  = (state_q == S_SPLIT) || (state_q == S_HPF) || (state_q == S_LPF);
  assign cnt_nx   = (cnt_q == 2'd3) ? 2'd1 : cnt_q + 2'd1;
  assign k        = cnt_q - 2'd1;
  assign k2       = (k == 2'd0) ? 2'd2 : k - 2'd1;
  assign k1       = (k == 2'd2) ? 2'd0 : k + 2'd1;
  assign xin      = {s_axis_tdata_i[SAMPLE_BITS-1:0], {GUARD_BITS{1'b0}}};
  assign prev_x   = {prev_q, {GUARD_BITS{1'b0}}};
  assign rdm      = rd_valid_q ? ram_rdata : '0;
  assign prod_sh  = prod_q[MW-1:16];
  assign mul_p    = mul_a * mul_b;
  assign p_new    = sat_st(PW'(s_q) + prod_sh);

  always_comb begin
    case (idx_q)
      3'd0:    dd = td_q;
      3'd1:    dd = md_q;
      default: dd = bd_q;
    endcase
    case (idx_q)
      3'd0:    dv = high_q;
      3'd1:    dv = mid_q;
      default: dv = bass_q;
    endcase
    absd = dd[17] ? -(19'(dd)) : 19'(dd);
    case (idx_q)
      3'd0:    emph_addr = EMPH_BASE + ENT_AW'(k);
      3'd1:    emph_addr = EMPH_BASE + ENT_AW'(k2);
      default: emph_addr = EMPH_BASE + ENT_AW'(k1);
    endcase
    case (idx_q)
      3'd0:    emph_val = sat_st(PW'(rdm) + PW'(f_q));
      3'd1:    emph_val = sat_st(PW'(rdm) - PW'(f_q));
      default: emph_val = rdm;
    endcase
  end

  always_comb begin
    p_addr = '0;
    p_in   = '0;
    p_coef = '0;
    unique case (state_q)
      S_SPLIT: begin
        unique case (idx_q)
          3'd0: begin
            p_addr = TREB_BASE + 6'd2 + ENT_AW'(k); p_in = EW'(x_q); p_coef = ca;
          end
          3'd1: begin
            p_addr = BASS_BASE + 6'd2 + ENT_AW'(k); p_in = EW'(x_q); p_coef = cb;
          end
          3'd2: begin
            p_addr = TREB_BASE + ENT_AW'(!tog_q); p_in = EW'(high_q); p_coef = ca;
          end
          3'd3: begin
            p_addr = BASS_BASE + ENT_AW'(!tog_q); p_in = EW'(bass_q); p_coef = cb;
          end
          3'd4: begin
            p_addr = TREB_BASE + 6'd5; p_in = EW'(high_q); p_coef = ca;
          end
          default: begin
            p_addr = BASS_BASE + 6'd5; p_in = EW'(bass_q); p_coef = cb;
          end
        endcase
      end
      S_HPF: begin
        p_in   = EW'(y_q);
        p_coef = chp;
        if (idx_q < 3'd4) p_addr = HP_BASE + (tog_q ? 6'd0 : 6'd4) + ENT_AW'(idx_q);
        else p_addr = HP_BASE + 6'd4 + ENT_AW'(idx_q);
      end
      S_LPF: begin
        p_in   = EW'(y_q);
        p_coef = clp;
        if (idx_q < 3'd5) p_addr = LP_BASE + (tog_q ? 6'd0 : 6'd5) + ENT_AW'(idx_q);
        else p_addr = LP_BASE + 6'd10;
      end
      default: ;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_TF: begin
        mul_a = EW'(ek_q);
        mul_b = -(21'(td_q));
      end
      S_SPLIT, S_HPF, S_LPF: begin
        mul_a = diff_q;
        mul_b = 21'(p_coef);
      end
      S_DRIVE: begin
        case (sub_q)
          3'd0: begin mul_a = EW'(dv);      mul_b = 21'(dd);      end
          3'd2: begin mul_a = EW'(x1_q);    mul_b = 21'(absd);    end
          3'd4: begin mul_a = EW'(tdiff_q); mul_b = 21'(fr_q);    end
          default: begin mul_a = shp_q;     mul_b = 21'(absd);    end
        endcase
      end
      S_OUT: begin
        mul_a = EW'(y_q);
        mul_b = 21'(gain_q);
      end
      default: ;
    endcase
  end

  assign ram_re    = (sub_q == 3'd0);
  assign raddr     = (state_q == S_EMPH) ? emph_addr : p_addr;
  assign ram_we    = ((state_q == S_EMPH) && (sub_q == 3'd1)) ||
                     (pole_st && (sub_q == 3'd3) && !((state_q == S_LPF) && (idx_q == 3'd6)));
  assign ram_wdata = (state_q == S_EMPH) ? (emph_val >>> 1) : p_new;
  assign s_val     = ((state_q == S_LPF) && (idx_q == 3'd6)) ? g_q : rdm;

  tbseq_ram #(
    .WIDTH (STATE_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (raddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      td_q      <= '0;
      md_q      <= '0;
      bd_q      <= '0;
      tsc_q     <= 17'd4096;
      bsc_q     <= 17'd2048;
      lpc_q     <= COEF_ONE;
      hpc_q     <= '0;
      gain_q    <= 20'd65536;
      state_q   <= S_IDLE;
      sub_q     <= '0;
      idx_q     <= '0;
      tog_q     <= 1'b0;
      cnt_q     <= '0;
      prev_q    <= '0;
      valid_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_addr_i))
          REG_TREBLE_DRIVE: td_q   <= cfg_data_i[17:0];
          REG_MID_DRIVE:    md_q   <= cfg_data_i[17:0];
          REG_BASS_DRIVE:   bd_q   <= cfg_data_i[17:0];
          REG_TREBLE_SPLIT: tsc_q  <= cfg_data_i[16:0];
          REG_BASS_SPLIT:   bsc_q  <= cfg_data_i[16:0];
          REG_LOWPASS:      lpc_q  <= cfg_data_i[16:0];
          REG_HIGHPASS:     hpc_q  <= cfg_data_i[16:0];
          REG_OUT_GAIN:     gain_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ram_we) valid_q[raddr] <= 1'b1;
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready_i) m_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            tog_q   <= ~tog_q;
            cnt_q   <= cnt_nx;
            prev_q  <= s_axis_tdata_i[SAMPLE_BITS-1:0];
            sub_q   <= '0;
            idx_q   <= '0;
            state_q <= S_EMPH;
          end
        end
        S_EMPH: begin
          if (sub_q == 3'd0) begin
            sub_q <= 3'd1;
          end else begin
            sub_q <= '0;
            if (idx_q == 3'd2) begin
              idx_q   <= '0;
              state_q <= S_TF;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        S_TF: begin
          if (sub_q == 3'd0) begin
            sub_q <= 3'd1;
          end else begin
            sub_q   <= '0;
            state_q <= S_SPLIT;
          end
        end
        S_SPLIT, S_HPF, S_LPF: begin
          if (sub_q != 3'd3) begin
            sub_q <= sub_q + 3'd1;
          end else begin
            sub_q <= '0;
            idx_q <= idx_q + 3'd1;
            if ((state_q == S_SPLIT) && (idx_q == 3'd5)) begin
              idx_q   <= '0;
              state_q <= S_MIX;
            end else if ((state_q == S_HPF) && (idx_q == 3'd5)) begin
              idx_q   <= '0;
              state_q <= lp_on ? S_LPF : S_OUT;
            end else if ((state_q == S_LPF) && (idx_q == 3'd6)) begin
              idx_q   <= '0;
              state_q <= S_OUT;
            end
          end
        end
        S_MIX: begin
          state_q <= S_DRIVE;
        end
        S_DRIVE: begin
          sub_q <= sub_q + 3'd1;
          if (sub_q == 3'd7) begin
            if (idx_q == 3'd2) begin
              idx_q   <= '0;
              state_q <= S_SUM;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        S_SUM: begin
          state_q <= hp_on ? S_HPF : (lp_on ? S_LPF : S_OUT);
        end
        S_OUT: begin
          // gain product in sub 0, scaled result in sub 1, then hand off
          if (sub_q < 3'd2) begin
            sub_q <= sub_q + 3'd1;
          end else if (out_load) begin
            sub_q   <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic [PW-1:0]          fx_w;
  logic [31:0]            sv;
  logic signed [EW-1:0]   mag, tpos;
  logic [TAB_AW:0]        idx_w;
  logic [TAB_AW-1:0]      ti, ti1;
  logic signed [PW-1:0]   ys, dres;
  logic                   oclamp;

  always_comb begin
    mag   = EW'(x1_q);
    if (mag < 0) mag = -mag;
    if (mag > ONE_FX) mag = ONE_FX;
    tpos  = (dd > 18'sd0) ? mag : ONE_FX - mag;
    idx_w = pos_q[PB-1:FRAC];
    oclamp = idx_w >= (TAB_AW+1)'(SINE_TABLE_DEPTH);
    ti    = oclamp ? TAB_AW'(SINE_TABLE_DEPTH - 1) : idx_w[TAB_AW-1:0];
    ti1   = ti + TAB_AW'(1);
    sv    = clamp_q ? 32'(Q30_ONE) : 32'(base_q) + prod_sh[31:0];
    fx_w  = PW'({sv, 9'b0} >> (39 - FRAC));
    dres  = PW'(x1_q) - m1_q + ((x1_q > 0) ? prod_sh : -prod_sh);
    ys    = PW'(y_q >>> GUARD_BITS);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (ram_re) rd_valid_q <= valid_q[raddr];
    if (pole_st && (sub_q == 3'd1)) begin
      s_q    <= s_val;
      diff_q <= p_in - EW'(s_val);
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_q    <= xin;
          f_q    <= sat_st(PW'(prev_x) - PW'(xin));
          last_q <= s_axis_tlast_i;
        end
      end
      S_EMPH: begin
        if ((sub_q == 3'd1) && (idx_q == 3'd0)) ek_q <= emph_val;
      end
      S_TF: begin
        if (sub_q == 3'd1) tf_q <= sat_st(prod_sh);
      end
      S_SPLIT: begin
        if ((sub_q == 3'd0) && (idx_q == 3'd1)) high_q <= sat_st(PW'(high_q) + PW'(tf_q));
        if (sub_q == 3'd3) begin
          if (idx_q[0]) bass_q <= p_new;
          else high_q <= sat_st(PW'(p_in) - PW'(p_new));
        end
      end
      S_MIX: begin
        mid_q <= sat_st(PW'(x_q) - PW'(bass_q) - PW'(high_q));
      end
      S_DRIVE: begin
        case (sub_q)
          3'd1: x1_q <= sat_st(PW'(dv) + prod_sh);
          3'd2: pos_q <= PB'(tpos[FRAC:0]) * PB'(SINE_TABLE_DEPTH);
          3'd3: begin
            m1_q    <= prod_sh;
            clamp_q <= oclamp;
            base_q  <= sin_tab[ti];
            tdiff_q <= sin_tab[ti1] - sin_tab[ti];
            fr_q    <= pos_q[FRAC-1 -: 16];
          end
          3'd5: shp_q <= (dd > 18'sd0) ? EW'(fx_w) : ONE_FX - EW'(fx_w);
          3'd7: begin
            case (idx_q)
              3'd0:    high_q <= sat_st(dres);
              3'd1:    mid_q  <= sat_st(dres);
              default: bass_q <= sat_st(dres);
            endcase
          end
          default: ;
        endcase
      end
      S_SUM: begin
        y_q <= sat_st(PW'(mid_q) + PW'(high_q) + PW'(bass_q));
      end
      S_HPF: begin
        if (sub_q == 3'd3) y_q <= sat_st(PW'(y_q) - PW'(p_new));
      end
      S_LPF: begin
        if (sub_q == 3'd3) begin
          if (idx_q == 3'd5) g_q <= p_new;
          else y_q <= p_new;
        end
      end
      S_OUT: begin
        if (sub_q == 3'd1) y_q <= sat_st(prod_sh);
        if (out_load) begin
          m_last_q <= last_q;
          if (ys > OUT_HI) begin
            m_data_q <= OUT_HI[SAMPLE_BITS-1:0];
            m_clip_q <= 1'b1;
          end else if (ys < OUT_LO) begin
            m_data_q <= OUT_LO[SAMPLE_BITS-1:0];
            m_clip_q <= 1'b1;
          end else begin
            m_data_q <= ys[SAMPLE_BITS-1:0];
            m_clip_q <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = TDW'(m_data_q);
  assign m_axis_tuser_o  = m_clip_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

`default_nettype wire

FILE: rtl/core/tbseq_ram.sv
// Generic simple dual port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module tbseq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 36
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sim/tb_three_band_saturating_eq.sv
// Self-checking testbench for three_band_saturating_eq.
// A bit-exact predictor of the band split, drive shaping and output filters checks each
// sample, mostly under random back-pressure. Depends on tbseq_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_three_band_saturating_eq;
  import tbseq_pkg::*;

  localparam longint SMAX = (64'sd1 <<< 39) - 1;
  localparam longint SMIN = -(64'sd1 <<< 39);
  localparam longint ONE_FX = 64'sd1 <<< 31;
  localparam int TAB_DEPTH = 256;
  localparam int PHASES = 15;
  localparam int PHASE_ITEMS = 130;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [23:0] sample;
    logic        clip;
    logic        last;
  } eq_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [23:0] s_data = '0;
  logic        s_last = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [23:0] m_data;
  logic        m_user;
  logic        m_last;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [19:0] cfg_data = '0;

  always #6 clk_i = ~clk_i;

  three_band_saturating_eq u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_data),    // [23:0] sample_in
    .s_axis_tlast_i (s_last),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .m_axis_tdata_o (m_data),    // [23:0] sample_out
    .m_axis_tuser_o (m_user),    // [0] clipped
    .m_axis_tlast_o (m_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_data_i     (cfg_data)
  );

  // predictor state
  logic [19:0] eq_regs [8];
  longint      prev_in;
  longint      emph [3];
  longint      treb [6];
  longint      bass_st [6];
  longint      hp [10];
  longint      lp [11];
  logic        toggle;
  int          phase_cnt;
  longint      sine_tab [TAB_DEPTH+1];

  eq_out_t     pending_q [$];
  int          errors = 0;
  int          n_sent = 0;
  int          n_recv = 0;
  int          n_clip = 0;
  bit          gap_en = 1'b1;
  bit          stall_en = 1'b1;
  longint      cycles = 0;

  function automatic longint sat40(longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic longint mulq(longint a, longint c);
    longint hi, lo;
    hi = a >>> 16;
    lo = a - hi * 65536;
    return hi * c + ((lo * c) >>> 16);
  endfunction

  function automatic longint pole(longint s, longint x, longint c);
    return sat40(s + mulq(x - s, c));
  endfunction

  function automatic longint taylor_sin(longint unsigned x);
    longint unsigned x2, term;
    longint sum;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    return sum;
  endfunction

  function automatic longint sine_q30(longint t);
    longint unsigned p, idx, fr;
    p = longint'(t) * TAB_DEPTH;
    idx = p >> 31;
    if (idx >= TAB_DEPTH) return sine_tab[TAB_DEPTH];
    fr = (p & (ONE_FX - 1)) >> 15;
    return sine_tab[idx] + longint'(((sine_tab[idx+1] - sine_tab[idx]) * fr) >> 16);
  endfunction

  function automatic longint drive_band(longint xin, longint d);
    longint x, mag, shp, a, y;
    x = sat40(xin + mulq(xin, d));
    mag = (x < 0) ? -x : x;
    if (mag > ONE_FX) mag = ONE_FX;
    if (d > 0) shp = sine_q30(mag) <<< 1;
    else shp = ONE_FX - (sine_q30(ONE_FX - mag) <<< 1);
    a = (d < 0) ? -d : d;
    y = x - mulq(x, a);
    if (x > 0) y += mulq(shp, a);
    else y -= mulq(shp, a);
    return sat40(y);
  endfunction

  function automatic longint coef_of(int i);
    return (eq_regs[i][16:0] > COEF_ONE) ? 64'sd65536 : longint'(eq_regs[i][16:0]);
  endfunction

  function automatic eq_out_t predict_sample(logic [23:0] smp, logic last);
    eq_out_t r;
    longint td, md, bd, ca, cb, clp, chp, gain, x, prev, f, tf, high, bss, mid, y, g;
    int k, bank, base;
    td = longint'(signed'(eq_regs[REG_TREBLE_DRIVE][17:0]));
    md = longint'(signed'(eq_regs[REG_MID_DRIVE][17:0]));
    bd = longint'(signed'(eq_regs[REG_BASS_DRIVE][17:0]));
    ca = coef_of(REG_TREBLE_SPLIT);
    cb = coef_of(REG_BASS_SPLIT);
    clp = coef_of(REG_LOWPASS);
    chp = coef_of(REG_HIGHPASS);
    gain = longint'(eq_regs[REG_OUT_GAIN]);
    x = longint'(signed'(smp)) * 256;
    prev = prev_in * 256;
    toggle = ~toggle;
    phase_cnt = (phase_cnt + 1) & 3;
    if (phase_cnt == 0) phase_cnt = 1;
    k = phase_cnt - 1;
    f = sat40(prev - x);
    emph[k] = sat40(emph[k] + f);
    emph[(k + 2) % 3] = sat40(emph[(k + 2) % 3] - f);
    tf = sat40(mulq(emph[k], -td));
    treb[2+k] = pole(treb[2+k], x, ca);
    high = sat40(x - treb[2+k]);
    bass_st[2+k] = pole(bass_st[2+k], x, cb);
    bss = bass_st[2+k];
    for (int i = 0; i < 3; i++) emph[i] = emph[i] >>> 1;
    high = sat40(high + tf);
    bank = toggle ? 0 : 1;
    treb[bank] = pole(treb[bank], high, ca);
    high = sat40(high - treb[bank]);
    bass_st[bank] = pole(bass_st[bank], bss, cb);
    bss = bass_st[bank];
    treb[5] = pole(treb[5], high, ca);
    high = sat40(high - treb[5]);
    bass_st[5] = pole(bass_st[5], bss, cb);
    bss = bass_st[5];
    mid = sat40(x - bss - high);
    high = drive_band(high, td);
    mid = drive_band(mid, md);
    bss = drive_band(bss, bd);
    y = sat40(mid + high + bss);
    if (chp != 0) begin
      base = toggle ? 0 : 4;
      for (int i = 0; i < 4; i++) begin
        hp[base+i] = pole(hp[base+i], y, chp);
        y = sat40(y - hp[base+i]);
      end
      hp[8] = pole(hp[8], y, chp);
      y = sat40(y - hp[8]);
      hp[9] = pole(hp[9], y, chp);
      y = sat40(y - hp[9]);
    end
    if (clp < 65536) begin
      base = toggle ? 0 : 5;
      for (int i = 0; i < 5; i++) begin
        lp[base+i] = pole(lp[base+i], y, clp);
        y = lp[base+i];
      end
      lp[10] = pole(lp[10], y, clp);
      g = lp[10];
      y = sat40(g + mulq(y - g, clp));
    end
    y = sat40(mulq(y, gain)) >>> 8;
    r.clip = 1'b0;
    if (y > 64'sd8388607) begin
      y = 64'sd8388607;
      r.clip = 1'b1;
    end else if (y < -64'sd8388608) begin
      y = -64'sd8388608;
      r.clip = 1'b1;
    end
    r.sample = y[23:0];
    r.last = last;
    prev_in = longint'(signed'(smp));
    return r;
  endfunction

  task automatic send_sample(logic [23:0] smp, logic last);
    if (gap_en && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= smp;
    s_last <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    pending_q.push_back(predict_sample(smp, last));
    n_sent++;
  endtask

  task automatic drain;
    s_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(reg_idx_e r, logic [19:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= r;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (r)
      REG_TREBLE_DRIVE, REG_MID_DRIVE, REG_BASS_DRIVE: eq_regs[r] = {2'b0, v[17:0]};
      REG_OUT_GAIN: eq_regs[r] = v;
      default: eq_regs[r] = {3'b0, v[16:0]};
    endcase
  endtask

  function automatic logic [19:0] rand_drive;
    case ($urandom_range(0, 5))
      0: return 20'h38000; // -32768
      1: return 20'd65536;
      2: return 20'd0;
      3: return 20'($urandom_range(0, 262143));
      default: return 20'(($urandom_range(0, 98304) - 32768) & 18'h3FFFF);
    endcase
  endfunction

  function automatic logic [19:0] rand_coef;
    case ($urandom_range(0, 7))
      0: return 20'd0;
      1: return 20'd65536;
      2: return 20'($urandom_range(65537, 131071));
      3: return 20'($urandom_range(1, 255));
      default: return 20'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [23:0] rand_sample;
    case ($urandom_range(0, 5))
      0: return 24'($urandom);
      1: return 24'h7FFFFF;
      2: return 24'h800000;
      3: return 24'(signed'(24'($urandom)) >>> $urandom_range(4, 20));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    logic [23:0] pat [8];
    pat = '{24'h0, 24'h0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h1, 24'hFFFFFF};
    foreach (pat[i]) send_sample(pat[i], i == 7);
    drain();
    // extreme drives, above-one highpass, lowpass at zero, full gain
    set_reg(REG_TREBLE_DRIVE, 20'd65536);
    set_reg(REG_MID_DRIVE, 20'h38000);
    set_reg(REG_BASS_DRIVE, 20'h1FFFF);
    set_reg(REG_HIGHPASS, 20'd131071);
    set_reg(REG_LOWPASS, 20'd0);
    set_reg(REG_OUT_GAIN, 20'hFFFFF);
    foreach (pat[i]) send_sample(pat[i], i[0]);
    drain();
    set_reg(REG_TREBLE_DRIVE, 20'h20000);
    set_reg(REG_MID_DRIVE, 20'h1FFFF);
    set_reg(REG_BASS_DRIVE, 20'd65536);
    set_reg(REG_TREBLE_SPLIT, 20'd0);
    set_reg(REG_BASS_SPLIT, 20'd131071);
    set_reg(REG_LOWPASS, 20'd1000);
    set_reg(REG_HIGHPASS, 20'd1);
    set_reg(REG_OUT_GAIN, 20'd0);
    for (int i = 0; i < 4; i++) send_sample(pat[2 + i], 1'b1);
    drain();
    set_reg(REG_OUT_GAIN, 20'd524288);
    for (int i = 0; i < 4; i++) send_sample(pat[2 + i], 1'b0);
    drain();
  endtask

  task automatic test_random;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        gap_en = 1'b0;
        stall_en = 1'b0;
      end
      set_reg(REG_TREBLE_DRIVE, rand_drive());
      set_reg(REG_MID_DRIVE, rand_drive());
      set_reg(REG_BASS_DRIVE, rand_drive());
      set_reg(REG_TREBLE_SPLIT, rand_coef());
      set_reg(REG_BASS_SPLIT, rand_coef());
      set_reg(REG_LOWPASS, rand_coef());
      set_reg(REG_HIGHPASS, rand_coef());
      set_reg(REG_OUT_GAIN, ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 1048575))
                                                          : 20'($urandom_range(0, 524288)));
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(rand_sample(), $urandom_range(0, 7) == 0);
      drain();
    end
  endtask

  // result side: random stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (stall_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    eq_out_t e;
    if (rst_ni && m_valid && m_ready) begin
      n_recv++;
      if (pending_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (m_data != e.sample) begin
          $error("sample_out expected %h got %h", e.sample, m_data);
          errors++;
        end
        if (m_user != e.clip) begin
          $error("clipped expected %b got %b", e.clip, m_user);
          errors++;
        end
        if (m_last != e.last) begin
          $error("block_end_out expected %b got %b", e.last, m_last);
          errors++;
        end
        if (e.clip) n_clip++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    eq_regs = '{20'd0, 20'd0, 20'd0, 20'd4096, 20'd2048, 20'd65536, 20'd0, 20'd65536};
    prev_in = 0;
    emph = '{default: 0};
    treb = '{default: 0};
    bass_st = '{default: 0};
    hp = '{default: 0};
    lp = '{default: 0};
    toggle = 1'b0;
    phase_cnt = 0;
    for (int i = 0; i <= TAB_DEPTH; i++)
      sine_tab[i] = taylor_sin(longint'(HALF_PI_Q30) * i / TAB_DEPTH);
    sine_tab[0] = 0;
    sine_tab[TAB_DEPTH] = 64'sd1 <<< 30;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    repeat (120) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d results never arrived", pending_q.size());
      errors++;
    end
    $display("%0d samples sent, %0d results checked (%0d clipped), %0d register settings",
             n_sent, n_recv, n_clip, PHASES + 4);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
